// File: sv/mtg_pkg.sv
`default_nettype none
package mtg_pkg;

  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned TWIST_SHIFT = 397;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned IDX_W       = $clog2(STATE_WORDS);

  localparam logic [WORD_W-1:0] INIT_MULT  = 32'd1812433253;
  localparam logic [WORD_W-1:0] TWIST_MAG  = 32'h9908B0DF;
  localparam logic [WORD_W-1:0] UPPER_MASK = 32'h80000000;
  localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7FFFFFFF;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9D2C5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hEFC60000;

  typedef logic [WORD_W-1:0] word_t;

  // item codes
  localparam logic MODE_SEED = 1'b0;
  localparam logic MODE_NEXT = 1'b1;

  function automatic word_t twist_word(word_t cur, word_t nxt, word_t far);
    word_t y;
    word_t v;
    y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MAG;
    end
    return v;
  endfunction

  function automatic word_t temper(word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage
`default_nettype wire

// File: sv/mtg_if.sv
`default_nettype none
interface mtg_cmd_if import mtg_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  mode;
  word_t seed;

  modport source (output valid, output mode, output seed, input ready);
  modport sink   (input valid, input mode, input seed, output ready);
endinterface

interface mtg_rnd_if import mtg_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface
`default_nettype wire

// File: sv/mersenne_twister_generator_top.sv
`default_nettype none
// MT19937 generator, 32-bit. The 624-word state lives in a ring of cells
// that shift one place towards the head on each step; the head always holds
// the oldest word. A seed item (mode 0) gives no result and fills the ring
// with the seed, then one word per cycle from a single 32x32 multiplier
// working on the word last pushed at the tail; the command channel is not
// ready during that time. A next item (mode 1) renews the head word by the
// twist (head, its neighbour and the word 397 places on), tempers it as the
// result and pushes the renewed word in at the tail, so the twist runs one
// word per item and a next item is taken every cycle while the skid register
// is empty. Results pass through an output register backed by one skid
// register. Asking for a number before the first seed gives undefined words.
module mersenne_twister_generator_top import mtg_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  mtg_cmd_if.sink   cmd,
  mtg_rnd_if.source rnd
);

  typedef enum logic {ST_IDLE, ST_FILL} state_t;

  state_t           state;
  logic [IDX_W-1:0] fill_cnt;
  logic             out_valid;
  word_t            out_word;
  logic             skid_valid;
  word_t            skid_word;

  word_t chain [STATE_WORDS];
  word_t tail_d;
  word_t renewed;
  word_t tempered;
  word_t fill_word;
  word_t mix;
  logic  accept;
  logic  shift;

  assign cmd.ready = (state == ST_IDLE) && !skid_valid;
  assign accept    = cmd.valid && cmd.ready;
  assign shift     = (state == ST_FILL) || accept;

  // ring of state words; chain[0] is the head
  for (genvar j = 0; j < STATE_WORDS; j++) begin : g_cell
    word_t d;
    if (j == STATE_WORDS - 1) begin : g_tail
      assign d = tail_d;
    end else begin : g_body
      assign d = chain[j+1];
    end
    mtg_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     (d),
      .q     (chain[j])
    );
  end

  mtg_twist u_twist (
    .head     (chain[0]),
    .head_nxt (chain[1]),
    .far      (chain[TWIST_SHIFT]),
    .renewed  (renewed),
    .tempered (tempered)
  );

  // seeding recurrence from the last word pushed
  assign mix       = chain[STATE_WORDS-1] ^ (chain[STATE_WORDS-1] >> 30);
  assign fill_word = WORD_W'(fill_cnt) + INIT_MULT * mix;

  always_comb begin
    if (state == ST_FILL) begin
      tail_d = fill_word;
    end else if (cmd.mode == MODE_SEED) begin
      tail_d = cmd.seed;
    end else begin
      tail_d = renewed;
    end
  end

  assign rnd.valid  = out_valid;
  assign rnd.number = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_cnt   <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && cmd.mode == MODE_SEED) begin
            fill_cnt <= IDX_W'(1);
            state    <= ST_FILL;
          end
        end
        ST_FILL: begin
          fill_cnt <= fill_cnt + IDX_W'(1);
          if (fill_cnt == IDX_W'(STATE_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // output register and skid
      if (accept && cmd.mode == MODE_NEXT) begin
        if (out_valid && !rnd.ready) begin
          skid_word  <= tempered;
          skid_valid <= 1'b1;
        end else begin
          out_word  <= tempered;
          out_valid <= 1'b1;
        end
      end else if (out_valid && rnd.ready) begin
        if (skid_valid) begin
          out_word   <= skid_word;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while output register is empty");

  a_seed_starts_fill: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.mode == MODE_SEED) |=> (state == ST_FILL && fill_cnt == IDX_W'(1)))
    else $error("seed item did not start the fill");

  a_fill_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && fill_cnt == IDX_W'(STATE_WORDS - 1)) |=> state == ST_IDLE)
    else $error("fill ran past the last word");

  a_no_take_in_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> !accept)
    else $error("item taken while filling");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rnd.ready && !(accept && cmd.mode == MODE_NEXT)) |=> $stable(skid_valid))
    else $error("skid changed while output stalled");

endmodule
`default_nettype wire

// File: sv/mtg_cell.sv
`default_nettype none
// One word of the state ring; takes its neighbour's word on each shift.
module mtg_cell import mtg_pkg::*; (
  input  wire   clk,
  input  wire   shift,
  input  word_t d,
  output word_t q
);

  word_t word;

  always_ff @(posedge clk) begin
    if (shift) begin
      word <= d;
    end
  end

  assign q = word;

endmodule
`default_nettype wire

// File: sv/mtg_twist.sv
`default_nettype none
// Renews the head word and tempers it.
module mtg_twist import mtg_pkg::*; (
  input  word_t head,
  input  word_t head_nxt,
  input  word_t far,
  output word_t renewed,
  output word_t tempered
);

  assign renewed  = twist_word(head, head_nxt, far);
  assign tempered = temper(renewed);

endmodule
`default_nettype wire
